@@ design/qsv_pkg.sv @@
// ----------------------------------------------------------------------------
// qsv_pkg
// Shared types and constants of the state-vector gate engine.
// ----------------------------------------------------------------------------
package qsv_pkg;

	localparam int QUBIT_COUNT_DEF = 10;
	localparam int Q_W            = 18;
	localparam int PROD_W         = 2 * Q_W;
	localparam int SUM_W          = PROD_W + 2;
	localparam logic signed [Q_W-1:0] Q_ONE = 18'sd65536;
	localparam logic signed [Q_W-1:0] Q_MAX = 18'sd131071;
	localparam logic signed [Q_W-1:0] Q_MIN = -18'sd131072;

	typedef enum logic [1:0] {
		CMD_VACUUM = 2'd0,
		CMD_GATE   = 2'd1,
		CMD_CGATE  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_X    = 2'd1,
		RD_Y    = 2'd2,
		RD_IDX  = 2'd3
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_CLR  = 2'd1,
		WR_X    = 2'd2,
		WR_Y    = 2'd3
	} wr_sel_t;

	typedef struct packed {
		logic    load;
		logic    cnt_clr;
		logic    cnt_inc;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    lat_x;
		logic    lat_y;
		logic    mul_en;
		logic [1:0] comp;
		logic    push;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic      reject;
		logic      skip;
		logic      last_all;
		logic      last_pair;
	} dp_stat_t;

endpackage

@@ design/qsv_ctrl.sv @@
// ----------------------------------------------------------------------------
// qsv_ctrl
// Sequencer: steps through vacuum fill, pair-wise gate updates and reads.
// ----------------------------------------------------------------------------
module qsv_ctrl import qsv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     out_free,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_DISP = 15'b000000000000010,
		S_CLR  = 15'b000000000000100,
		S_RX   = 15'b000000000001000,
		S_RY   = 15'b000000000010000,
		S_LY   = 15'b000000000100000,
		S_M0   = 15'b000000001000000,
		S_M1   = 15'b000000010000000,
		S_M2   = 15'b000000100000000,
		S_M3   = 15'b000001000000000,
		S_FIN  = 15'b000010000000000,
		S_WX   = 15'b000100000000000,
		S_WY   = 15'b001000000000000,
		S_RDA  = 15'b010000000000000,
		S_DONE = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic   boot_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				ctl.cnt_clr = 1'b1;
				case (stat.cmd)
					CMD_VACUUM: state_d = S_CLR;
					CMD_READ:   state_d = S_RDA;
					default:    state_d = stat.reject ? S_DONE : S_RX;
				endcase
			end
			S_CLR: begin
				ctl.wr_sel  = WR_CLR;
				ctl.cnt_inc = 1'b1;
				if (stat.last_all) begin
					state_d = boot_q ? S_IDLE : S_DONE;
				end
			end
			S_RX: begin
				if (stat.skip) begin
					ctl.cnt_inc = 1'b1;
					if (stat.last_pair) begin
						state_d = S_DONE;
					end
				end else begin
					ctl.rd_sel = RD_X;
					state_d    = S_RY;
				end
			end
			S_RY: begin
				ctl.rd_sel = RD_Y;
				ctl.lat_x  = 1'b1;
				state_d    = S_LY;
			end
			S_LY: begin
				ctl.lat_y = 1'b1;
				state_d   = S_M0;
			end
			S_M0: begin
				ctl.mul_en = 1'b1;
				ctl.comp   = 2'd0;
				state_d    = S_M1;
			end
			S_M1: begin
				ctl.mul_en = 1'b1;
				ctl.comp   = 2'd1;
				state_d    = S_M2;
			end
			S_M2: begin
				ctl.mul_en = 1'b1;
				ctl.comp   = 2'd2;
				state_d    = S_M3;
			end
			S_M3: begin
				ctl.mul_en = 1'b1;
				ctl.comp   = 2'd3;
				state_d    = S_FIN;
			end
			S_FIN: begin
				state_d = S_WX;
			end
			S_WX: begin
				ctl.wr_sel = WR_X;
				state_d    = S_WY;
			end
			S_WY: begin
				ctl.wr_sel  = WR_Y;
				ctl.cnt_inc = 1'b1;
				state_d     = stat.last_pair ? S_DONE : S_RX;
			end
			S_RDA: begin
				ctl.rd_sel = RD_IDX;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR && stat.last_all) begin
				boot_q <= 1'b0;
			end
		end
	end

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DISP) else $error("accepted item not dispatched");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> out_free) else $error("result pushed into full slot");
	a_pair_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WY |=> (state_q == S_RX || state_q == S_DONE))
		else $error("bad step after pair write");

endmodule

@@ design/qsv_dp.sv @@
// ----------------------------------------------------------------------------
// qsv_dp
// Datapath: amplitude memory, index counter and complex multiply-accumulate.
// ----------------------------------------------------------------------------
module qsv_dp import qsv_pkg::*; #(
	parameter int QUBIT_COUNT = QUBIT_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              ctl,
	input  logic [1:0]            command,
	input  logic [3:0]            target_qubit,
	input  logic [3:0]            control_qubit,
	input  logic [15:0]           read_index,
	input  logic signed [Q_W-1:0] gate_a_re,
	input  logic signed [Q_W-1:0] gate_a_im,
	input  logic signed [Q_W-1:0] gate_b_re,
	input  logic signed [Q_W-1:0] gate_b_im,
	input  logic signed [Q_W-1:0] gate_c_re,
	input  logic signed [Q_W-1:0] gate_c_im,
	input  logic signed [Q_W-1:0] gate_d_re,
	input  logic signed [Q_W-1:0] gate_d_im,
	output dp_stat_t              stat,
	output logic signed [Q_W-1:0] rd_re,
	output logic signed [Q_W-1:0] rd_im
);

	localparam int N = QUBIT_COUNT;
	localparam int DEPTH = 2 ** N;
	localparam logic [N-1:0] HALF_M1 = N'((2 ** (N - 1)) - 1);

	logic [2*Q_W-1:0] mem [DEPTH];

	cmd_code_t          cmd_q;
	logic [3:0]         targ_q, ctrl_q;
	logic [N-1:0]       idx_q;
	logic signed [Q_W-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
	logic signed [Q_W-1:0] c_re_q, c_im_q, d_re_q, d_im_q;
	logic [N-1:0]       cnt_q;
	logic [2*Q_W-1:0]   rdata_q;
	logic signed [Q_W-1:0] x_re_q, x_im_q, y_re_q, y_im_q;
	logic signed [Q_W-1:0] res_q [4];
	logic signed [PROD_W-1:0] prod_s1 [4];
	logic [1:0]         comp_s1;
	logic               mv_s1;

	logic [N-1:0] low_mask, x_addr, y_addr, raddr, waddr, ctrl_sh;
	logic         wr_en;
	logic [2*Q_W-1:0] wdata;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_code_t'(command);
			targ_q <= target_qubit;
			ctrl_q <= control_qubit;
			idx_q  <= read_index[N-1:0];
			a_re_q <= gate_a_re;
			a_im_q <= gate_a_im;
			b_re_q <= gate_b_re;
			b_im_q <= gate_b_im;
			c_re_q <= gate_c_re;
			c_im_q <= gate_c_im;
			d_re_q <= gate_d_re;
			d_im_q <= gate_d_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= ctl.mul_en;
			if (ctl.cnt_clr) begin
				cnt_q <= '0;
			end else if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// insert a zero at the target bit of the pair counter
	assign low_mask = ~({N{1'b1}} << targ_q);
	assign x_addr   = ((cnt_q & ~low_mask) << 1) | (cnt_q & low_mask);
	assign y_addr   = x_addr | (N'(1) << targ_q);

	always_comb begin
		case (ctl.rd_sel)
			RD_Y:    raddr = y_addr;
			RD_IDX:  raddr = idx_q;
			default: raddr = x_addr;
		endcase
		wr_en = 1'b1;
		case (ctl.wr_sel)
			WR_CLR: begin
				waddr = cnt_q;
				wdata = (cnt_q == '0) ? {Q_ONE, {Q_W{1'b0}}} : '0;
			end
			WR_X: begin
				waddr = x_addr;
				wdata = {res_q[0], res_q[1]};
			end
			WR_Y: begin
				waddr = y_addr;
				wdata = {res_q[2], res_q[3]};
			end
			default: begin
				wr_en = 1'b0;
				waddr = cnt_q;
				wdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_sel != RD_NONE) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.lat_x) begin
			x_re_q <= rdata_q[2*Q_W-1:Q_W];
			x_im_q <= rdata_q[Q_W-1:0];
		end
		if (ctl.lat_y) begin
			y_re_q <= rdata_q[2*Q_W-1:Q_W];
			y_im_q <= rdata_q[Q_W-1:0];
		end
	end

	// component: bit 1 picks the matrix row, bit 0 picks imaginary part
	logic signed [Q_W-1:0] m0re, m0im, m1re, m1im, xa, xb, ya, yb;
	always_comb begin
		m0re = ctl.comp[1] ? c_re_q : a_re_q;
		m0im = ctl.comp[1] ? c_im_q : a_im_q;
		m1re = ctl.comp[1] ? d_re_q : b_re_q;
		m1im = ctl.comp[1] ? d_im_q : b_im_q;
		xa   = ctl.comp[0] ? x_im_q : x_re_q;
		xb   = ctl.comp[0] ? x_re_q : x_im_q;
		ya   = ctl.comp[0] ? y_im_q : y_re_q;
		yb   = ctl.comp[0] ? y_re_q : y_im_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1[0] <= m0re * xa;
			prod_s1[1] <= m0im * xb;
			prod_s1[2] <= m1re * ya;
			prod_s1[3] <= m1im * yb;
			comp_s1    <= ctl.comp;
		end
	end

	logic signed [SUM_W-1:0]   pos_sum, cross_sum, tot_sum;
	logic signed [SUM_W:0]     rnd;
	logic signed [SUM_W-16:0]  shr;
	logic signed [Q_W-1:0]     sat;
	always_comb begin
		pos_sum   = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[2]);
		cross_sum = SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[3]);
		tot_sum   = comp_s1[0] ? pos_sum + cross_sum : pos_sum - cross_sum;
		rnd       = (SUM_W + 1)'(tot_sum) + (SUM_W + 1)'(32768);
		shr       = rnd[SUM_W:16];
		if (shr > (SUM_W - 15)'(Q_MAX)) begin
			sat = Q_MAX;
		end else if (shr < (SUM_W - 15)'(Q_MIN)) begin
			sat = Q_MIN;
		end else begin
			sat = shr[Q_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			res_q[comp_s1] <= sat;
		end
	end

	logic [4:0] targ_w, ctrl_w;
	logic       bad_t, bad_c;
	assign targ_w = {1'b0, targ_q};
	assign ctrl_w = {1'b0, ctrl_q};
	assign bad_t  = (targ_w >= 5'(N));
	assign bad_c  = (ctrl_w >= 5'(N)) || (ctrl_q == targ_q);

	// bring the control bit of the lower index down to bit 0
	assign ctrl_sh = x_addr >> ctrl_q;

	assign stat.cmd       = cmd_q;
	assign stat.reject    = bad_t || ((cmd_q == CMD_CGATE) && bad_c);
	assign stat.skip      = (cmd_q == CMD_CGATE) && !ctrl_sh[0];
	assign stat.last_all  = (cnt_q == {N{1'b1}});
	assign stat.last_pair = (cnt_q == HALF_M1);

	assign rd_re = (cmd_q == CMD_READ) ? rdata_q[2*Q_W-1:Q_W] : '0;
	assign rd_im = (cmd_q == CMD_READ) ? rdata_q[Q_W-1:0] : '0;

endmodule

@@ design/quantum_state_vector_gate_engine.sv @@
// ----------------------------------------------------------------------------
// quantum_state_vector_gate_engine
// State vector of 2^QUBIT_COUNT Q2.16 complex amplitudes with vacuum load,
// single-qubit and controlled 2x2 gates, and amplitude read-back.
// ----------------------------------------------------------------------------
// A rejected gate goes straight to its result; a controlled gate steps over each
// pair whose control bit is clear without reading or writing it.
// The pair loop shares one memory port: two reads, four multiply steps and
// two writes per pair. One item is handled at a time.
// Reset runs a fill of the vacuum state; no item is taken meanwhile.
module quantum_state_vector_gate_engine import qsv_pkg::*; #(
	parameter int QUBIT_COUNT = QUBIT_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  logic [3:0]            target_qubit,
	input  logic [3:0]            control_qubit,
	input  logic [15:0]           read_index,
	input  logic signed [Q_W-1:0] gate_a_re,
	input  logic signed [Q_W-1:0] gate_a_im,
	input  logic signed [Q_W-1:0] gate_b_re,
	input  logic signed [Q_W-1:0] gate_b_im,
	input  logic signed [Q_W-1:0] gate_c_re,
	input  logic signed [Q_W-1:0] gate_c_im,
	input  logic signed [Q_W-1:0] gate_d_re,
	input  logic signed [Q_W-1:0] gate_d_im,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [Q_W-1:0] amp_re,
	output logic signed [Q_W-1:0] amp_im,
	output logic                  status
);

	ctl_cmd_t ctl;
	dp_stat_t stat;
	logic signed [Q_W-1:0] rd_re, rd_im;
	logic out_valid_q, out_free;
	logic signed [Q_W-1:0] amp_re_q, amp_im_q;
	logic status_q;

	// the output slot is free when empty or when its item is taken in this cycle
	assign out_free = !out_valid_q || !out_stall;

	qsv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_free (out_free),
		.stat     (stat),
		.ctl      (ctl)
	);

	qsv_dp #(.QUBIT_COUNT(QUBIT_COUNT)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.command       (command),
		.target_qubit  (target_qubit),
		.control_qubit (control_qubit),
		.read_index    (read_index),
		.gate_a_re     (gate_a_re),
		.gate_a_im     (gate_a_im),
		.gate_b_re     (gate_b_re),
		.gate_b_im     (gate_b_im),
		.gate_c_re     (gate_c_re),
		.gate_c_im     (gate_c_im),
		.gate_d_re     (gate_d_re),
		.gate_d_im     (gate_d_im),
		.stat          (stat),
		.rd_re         (rd_re),
		.rd_im         (rd_im)
	);

	// hold the result until taken; load a new one when the controller pushes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			amp_re_q <= rd_re;
			amp_im_q <= rd_im;
			status_q <= stat.reject && (stat.cmd == CMD_GATE || stat.cmd == CMD_CGATE);
		end
	end

	assign out_valid = out_valid_q;
	assign amp_re    = amp_re_q;
	assign amp_im    = amp_im_q;
	assign status    = status_q;

endmodule
